### hdl/abes_pkg.sv
// package for the alu / branch execute stage
// word layouts, opcodes, stage record; unused by abes_chan_if; no dependencies
`timescale 1ns / 1ps

package abes_pkg;

	localparam int DATA_W  = 32;
	localparam int PC_W    = 16;
	localparam int IMM_W   = 16;
	localparam int CMD_W   = 5;
	localparam int SHAMT_W = $clog2(DATA_W);

	// opcodes
	localparam logic [CMD_W-1:0] CMD_ADD   = 5'b00000;
	localparam logic [CMD_W-1:0] CMD_ADD1  = 5'b00001;
	localparam logic [CMD_W-1:0] CMD_SUB   = 5'b00010;
	localparam logic [CMD_W-1:0] CMD_ZERO  = 5'b00011;
	localparam logic [CMD_W-1:0] CMD_XOR   = 5'b00100;
	localparam logic [CMD_W-1:0] CMD_OR    = 5'b00101;
	localparam logic [CMD_W-1:0] CMD_NOTA  = 5'b00110;
	localparam logic [CMD_W-1:0] CMD_AND   = 5'b00111;
	localparam logic [CMD_W-1:0] CMD_ASL   = 5'b01000;
	localparam logic [CMD_W-1:0] CMD_ASR   = 5'b01001;
	localparam logic [CMD_W-1:0] CMD_LSL   = 5'b01010;
	localparam logic [CMD_W-1:0] CMD_LSR   = 5'b01011;
	localparam logic [CMD_W-1:0] CMD_PASSA = 5'b01100;
	localparam logic [CMD_W-1:0] CMD_NOR   = 5'b01101;
	localparam logic [CMD_W-1:0] CMD_LCH   = 5'b01110;
	localparam logic [CMD_W-1:0] CMD_LCL   = 5'b01111;
	localparam logic [CMD_W-1:0] CMD_JAL   = 5'b10010;
	localparam logic [CMD_W-1:0] CMD_JR    = 5'b10011;
	localparam logic [CMD_W-1:0] CMD_BEQ   = 5'b10101;
	localparam logic [CMD_W-1:0] CMD_BNE   = 5'b10110;
	localparam logic [CMD_W-1:0] CMD_J     = 5'b10111;
	localparam logic [CMD_W-1:0] CMD_SUBI  = 5'b11000;
	localparam logic [CMD_W-1:0] CMD_BGE   = 5'b11001;
	localparam logic [CMD_W-1:0] CMD_BLE   = 5'b11010;
	localparam logic [CMD_W-1:0] CMD_BGT   = 5'b11100;
	localparam logic [CMD_W-1:0] CMD_BLT   = 5'b11101;
	localparam logic [CMD_W-1:0] CMD_NAND  = 5'b11110;
	localparam logic [CMD_W-1:0] CMD_MUL   = 5'b11111;

	// instruction word entering the stage
	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [DATA_W-1:0] operand_a;
		logic [DATA_W-1:0] operand_b;
		logic [IMM_W-1:0]  immediate;
		logic              use_immediate;
		logic              is_branch;
		logic              is_jump;
		logic [PC_W-1:0]   current_pc;
	} in_word_t;

	// result word leaving the stage
	typedef struct packed {
		logic [DATA_W-1:0] alu_result;
		logic [PC_W-1:0]   next_pc;
		logic              zero_flag;
		logic              carry_flag;
		logic              overflow_flag;
		logic              negative_flag;
	} out_word_t;

	// execute record handed to the flag stage
	typedef struct packed {
		logic [DATA_W-1:0] result;
		logic [PC_W-1:0]   next_pc;
		logic              carry;
		logic              overflow;
		logic              is_mul;
		logic [DATA_W-1:0] prod_hi;
		logic [DATA_W-1:0] mul_corr;
	} exec_t;

endpackage

### hdl/abes_chan_if.sv
// valid/ready channel carrying one word of a given type
// word type comes from abes_pkg at instantiation
`timescale 1ns / 1ps

interface abes_chan_if #(
	parameter type word_t = logic
);
	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hdl/alu_branch_execute_stage_unit.sv
// alu / branch execute stage: an accepted word passes in order through the input register,
// the execute register and the result register before it is offered;
// one word per cycle sustained while the receiver takes results,
// each stage moves on as soon as the stage after it is empty or drains
// the multiplier sits between the input and execute registers
// reset clears the stage valid bits only; payload registers are not reset
`timescale 1ns / 1ps

module alu_branch_execute_stage_unit
	import abes_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	abes_chan_if.sink   inp,
	abes_chan_if.source res
);

	logic      v_s1, v_s2, v_s3;
	logic      en_s1, en_s2, en_s3;
	in_word_t  d_s1;
	exec_t     d_s2;
	out_word_t d_s3;
	exec_t     exe_c;
	out_word_t fin_c;

	// per-stage load enables
	assign en_s3     = ~v_s3 | res.ready;
	assign en_s2     = ~v_s2 | en_s3;
	assign en_s1     = ~v_s1 | en_s2;
	assign inp.ready = en_s1;

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= inp.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (en_s1 && inp.valid) d_s1 <= inp.data;
		if (en_s2 && v_s1)      d_s2 <= exe_c;
		if (en_s3 && v_s2)      d_s3 <= fin_c;
	end

	abes_exec u_exec (
		.word (d_s1),
		.exe  (exe_c)
	);

	abes_flags u_flags (
		.exe  (d_s2),
		.word (fin_c)
	);

	assign res.valid = v_s3;
	assign res.data  = d_s3;

`ifndef SYNTHESIS
	// jump and link writes the old pc as result
	a_jal_link: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && en_s2 && d_s1.is_jump && d_s1.cmd == CMD_JAL) |=>
		(d_s2.result == {{(DATA_W-PC_W){1'b0}}, $past(d_s1.current_pc)}))
		else $error("jal result is not the old pc");

	// no jump and no branch leaves the pc unchanged
	a_pc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && en_s2 && !d_s1.is_jump && !d_s1.is_branch) |=>
		(d_s2.next_pc == $past(d_s1.current_pc)))
		else $error("pc changed without jump or branch");

	// an empty result register never blocks the input
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s3 |-> inp.ready)
		else $error("input stalled with empty result register");
`endif

endmodule

### hdl/abes_exec.sv
// execute logic: alu, multiplier, branch and jump resolution
// depends on abes_pkg
`timescale 1ns / 1ps

module abes_exec
	import abes_pkg::*;
(
	input  in_word_t word,
	output exec_t    exe
);

	logic [DATA_W-1:0]   a;
	logic [DATA_W-1:0]   b;
	logic [DATA_W-1:0]   imm_x;
	logic [DATA_W-1:0]   r;
	logic [DATA_W-1:0]   res_x;
	logic [DATA_W:0]     sum;
	logic [DATA_W:0]     diff;
	logic [2*DATA_W-1:0] prod;
	logic [SHAMT_W-1:0]  sh;
	logic                big;
	logic                c;
	logic                v;
	logic                is_cmp;
	logic                take;
	logic [PC_W-1:0]     pc;

	// operand selection
	assign a     = word.operand_a;
	assign imm_x = {{(DATA_W-IMM_W){word.immediate[IMM_W-1]}}, word.immediate};
	assign b     = word.use_immediate ? imm_x : word.operand_b;

	// shared arithmetic
	assign sum  = {1'b0, a} + {1'b0, b};
	assign diff = {1'b0, a} - {1'b0, b};
	assign prod = {{DATA_W{1'b0}}, a} * {{DATA_W{1'b0}}, b};
	assign sh   = b[SHAMT_W-1:0];
	assign big  = |b[DATA_W-1:SHAMT_W];

	// alu result and arithmetic flags
	always_comb begin
		r = '0;
		c = 1'b0;
		v = 1'b0;
		case (word.cmd)
			CMD_ADD, CMD_ADD1: begin
				r = sum[DATA_W-1:0];
				c = sum[DATA_W];
				v = a[DATA_W-1] ~^ b[DATA_W-1] ? (a[DATA_W-1] ^ r[DATA_W-1]) : 1'b0;
			end
			CMD_SUB, CMD_SUBI, CMD_BEQ, CMD_BNE, CMD_BGT, CMD_BLT, CMD_BGE, CMD_BLE: begin
				r = diff[DATA_W-1:0];
				c = ~diff[DATA_W];
				v = (a[DATA_W-1] ^ b[DATA_W-1]) & (a[DATA_W-1] ^ r[DATA_W-1]);
			end
			CMD_ZERO:  r = '0;
			CMD_XOR:   r = a ^ b;
			CMD_OR:    r = a | b;
			CMD_NOTA:  r = ~a;
			CMD_AND:   r = a & b;
			CMD_ASL: begin
				r = big ? '0 : (a << sh);
				r[DATA_W-1] = a[DATA_W-1];
			end
			CMD_ASR:   r = big ? {DATA_W{a[DATA_W-1]}} : DATA_W'($signed(a) >>> sh);
			CMD_LSL:   r = big ? '0 : (a << sh);
			CMD_LSR:   r = big ? '0 : (a >> sh);
			CMD_PASSA: r = a;
			CMD_NOR:   r = ~(a | b);
			CMD_LCH:   r = b << IMM_W;
			CMD_LCL:   r = b;
			CMD_NAND:  r = ~(a & b);
			CMD_MUL:   r = prod[DATA_W-1:0];
			default:   r = '0;
		endcase
	end

	// signed compare for the conditional branches
	always_comb begin
		is_cmp = word.cmd inside {CMD_BEQ, CMD_BNE, CMD_BGT, CMD_BLT, CMD_BGE, CMD_BLE};
		case (word.cmd)
			CMD_BEQ: take = (a == b);
			CMD_BNE: take = (a != b);
			CMD_BGT: take = ($signed(a) > $signed(b));
			CMD_BLT: take = ($signed(a) < $signed(b));
			CMD_BGE: take = ($signed(a) >= $signed(b));
			CMD_BLE: take = ($signed(a) <= $signed(b));
			default: take = 1'b0;
		endcase
	end

	// next pc and jump-and-link result
	always_comb begin
		pc    = word.current_pc;
		res_x = r;
		if (word.is_jump) begin
			case (word.cmd)
				CMD_JAL: begin
					res_x = {{(DATA_W-PC_W){1'b0}}, word.current_pc};
					pc    = word.immediate[PC_W-1:0];
				end
				CMD_JR:  pc = a[PC_W-1:0];
				CMD_J:   pc = word.immediate[PC_W-1:0];
				default: pc = word.current_pc;
			endcase
		end
		if (word.is_branch && is_cmp && take) begin
			pc = word.current_pc + imm_x[PC_W-1:0];
		end
	end

	// hand-off record; mul flags are settled in the next stage
	assign exe.result   = res_x;
	assign exe.next_pc  = pc;
	assign exe.carry    = c;
	assign exe.overflow = v;
	assign exe.is_mul   = (word.cmd == CMD_MUL);
	assign exe.prod_hi  = prod[2*DATA_W-1:DATA_W];
	assign exe.mul_corr = (a[DATA_W-1] ? b : '0) + (b[DATA_W-1] ? a : '0);

endmodule

### hdl/abes_flags.sv
// flag stage: multiply carry/overflow and result status flags
// depends on abes_pkg
`timescale 1ns / 1ps

module abes_flags
	import abes_pkg::*;
(
	input  exec_t     exe,
	output out_word_t word
);

	logic [DATA_W-1:0] hi_signed;

	// signed high half from the unsigned product
	assign hi_signed = exe.prod_hi - exe.mul_corr;

	always_comb begin
		word.alu_result    = exe.result;
		word.next_pc       = exe.next_pc;
		word.zero_flag     = (exe.result == '0);
		word.negative_flag = exe.result[DATA_W-1];
		if (exe.is_mul) begin
			word.carry_flag    = |exe.prod_hi;
			word.overflow_flag = (hi_signed != {DATA_W{exe.result[DATA_W-1]}});
		end else begin
			word.carry_flag    = exe.carry;
			word.overflow_flag = exe.overflow;
		end
	end

endmodule

### test/tb_top.sv
// self-checking bench for alu_branch_execute_stage_unit: directed instruction words,
// then random ones, checked against an in-bench execute predictor
// depends on abes_pkg and abes_chan_if from hdl
`timescale 1ns / 1ps

module tb_top
	import abes_pkg::*;
();

	localparam int MAX_REPORTS = 40;
	localparam int RANDOM_WORDS = 850;

	// opcodes with no function in the stage
	localparam logic [CMD_W-1:0] CMD_RSV_10000 = 5'b10000;
	localparam logic [CMD_W-1:0] CMD_RSV_10001 = 5'b10001;
	localparam logic [CMD_W-1:0] CMD_RSV_10100 = 5'b10100;
	localparam logic [CMD_W-1:0] CMD_RSV_11011 = 5'b11011;

	logic clk = 1'b0;
	logic arst_n;

	abes_chan_if #(.word_t(in_word_t))  insn_ch ();
	abes_chan_if #(.word_t(out_word_t)) result_ch ();

	alu_branch_execute_stage_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.inp    (insn_ch),
		.res    (result_ch)
	);

	out_word_t due_results[$];
	int        fail_count = 0;
	int        result_count = 0;
	int        burst_left = 0;

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// expected execute result of one instruction word
	function automatic out_word_t execute_instr(input in_word_t w);
		out_word_t   o;
		logic [31:0] a, b, r;
		logic [32:0] sum;
		logic [63:0] uprod;
		longint      sa_l, sb_l, sprod;
		logic [15:0] pc;
		logic        c, v, cmp_op, take;
		a = w.operand_a;
		b = w.use_immediate ? {{16{w.immediate[15]}}, w.immediate} : w.operand_b;
		pc = w.current_pc;
		r = '0;
		c = 1'b0;
		v = 1'b0;
		cmp_op = 1'b0;
		take = 1'b0;
		case (w.cmd)
			CMD_ADD, CMD_ADD1: begin
				sum = {1'b0, a} + {1'b0, b};
				r = sum[31:0];
				c = sum[32];
				v = (a[31] == b[31]) && (r[31] != a[31]);
			end
			CMD_SUB, CMD_SUBI, CMD_BEQ, CMD_BNE, CMD_BGT, CMD_BLT, CMD_BGE, CMD_BLE: begin
				r = a - b;
				c = a >= b;
				v = (a[31] != b[31]) && (r[31] != a[31]);
				cmp_op = !(w.cmd inside {CMD_SUB, CMD_SUBI});
			end
			CMD_XOR:   r = a ^ b;
			CMD_OR:    r = a | b;
			CMD_NOTA:  r = ~a;
			CMD_AND:   r = a & b;
			CMD_ASL: begin
				r = (b >= 32) ? '0 : (a << b[4:0]);
				r[31] = a[31];
			end
			CMD_ASR:   r = (b >= 32) ? {32{a[31]}} : 32'($signed(a) >>> b[4:0]);
			CMD_LSL:   r = (b >= 32) ? '0 : (a << b[4:0]);
			CMD_LSR:   r = (b >= 32) ? '0 : (a >> b[4:0]);
			CMD_PASSA: r = a;
			CMD_NOR:   r = ~(a | b);
			CMD_LCH:   r = b << 16;
			CMD_LCL:   r = b;
			CMD_NAND:  r = ~(a & b);
			CMD_MUL: begin
				uprod = 64'(a) * 64'(b);
				r = uprod[31:0];
				c = |uprod[63:32];
				sa_l = longint'($signed(a));
				sb_l = longint'($signed(b));
				sprod = sa_l * sb_l;
				v = (sprod > 64'sd2147483647) || (sprod < -64'sd2147483648);
			end
			default:   r = '0;
		endcase

		// jumps, only when flagged
		if (w.is_jump) begin
			case (w.cmd)
				CMD_JAL: begin
					r = 32'(pc);
					pc = w.immediate;
				end
				CMD_JR:  pc = a[15:0];
				CMD_J:   pc = w.immediate;
				default: ;
			endcase
		end

		// signed-compare branches, pc wraps at 16 bits
		if (w.is_branch && cmp_op) begin
			case (w.cmd)
				CMD_BEQ: take = a == b;
				CMD_BNE: take = a != b;
				CMD_BGT: take = $signed(a) > $signed(b);
				CMD_BLT: take = $signed(a) < $signed(b);
				CMD_BGE: take = $signed(a) >= $signed(b);
				default: take = $signed(a) <= $signed(b);
			endcase
			if (take)
				pc = pc + w.immediate;
		end

		o.alu_result = r;
		o.next_pc = pc;
		o.zero_flag = (r == '0);
		o.carry_flag = c;
		o.overflow_flag = v;
		o.negative_flag = r[31];
		return o;
	endfunction

	function automatic in_word_t make_instr(input logic [CMD_W-1:0] cmd, input logic [31:0] a,
		input logic [31:0] b, input logic [15:0] imm, input int ui, input int br,
		input int jp, input logic [15:0] pc);
		in_word_t w;
		w.cmd = cmd;
		w.operand_a = a;
		w.operand_b = b;
		w.immediate = imm;
		w.use_immediate = ui[0];
		w.is_branch = br[0];
		w.is_jump = jp[0];
		w.current_pc = pc;
		return w;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		if (fail_count < MAX_REPORTS)
			$display("[%0t] result %0d: %s got %h want %h", $time, result_count, what, got, want);
		fail_count++;
	endtask

	// send one word; bursts of random length with random gaps between them
	task automatic send_instr(input in_word_t w);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				insn_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		insn_ch.valid <= 1'b1;
		insn_ch.data <= w;
		do @(posedge clk); while (!insn_ch.ready);
		due_results.push_back(execute_instr(w));
		@(negedge clk);
		burst_left--;
	endtask

	task automatic wait_for_drain();
		while (due_results.size() != 0)
			@(posedge clk);
	endtask

	// sender holds off until every outstanding result is back
	task automatic drain_pause();
		insn_ch.valid <= 1'b0;
		wait_for_drain();
		@(negedge clk);
		burst_left = 0;
	endtask

	// check each returned word against the oldest expectation
	always @(posedge clk) begin : result_check
		out_word_t got, want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got = result_ch.data;
			result_count++;
			if (due_results.size() == 0) begin
				report_mismatch("unexpected word, alu_result", got.alu_result, '0);
			end else begin
				want = due_results.pop_front();
				if (got.alu_result !== want.alu_result)
					report_mismatch("alu_result", got.alu_result, want.alu_result);
				if (got.next_pc !== want.next_pc)
					report_mismatch("next_pc", 32'(got.next_pc), 32'(want.next_pc));
				if (got.zero_flag !== want.zero_flag)
					report_mismatch("zero_flag", 32'(got.zero_flag), 32'(want.zero_flag));
				if (got.carry_flag !== want.carry_flag)
					report_mismatch("carry_flag", 32'(got.carry_flag), 32'(want.carry_flag));
				if (got.overflow_flag !== want.overflow_flag)
					report_mismatch("overflow_flag", 32'(got.overflow_flag),
						32'(want.overflow_flag));
				if (got.negative_flag !== want.negative_flag)
					report_mismatch("negative_flag", 32'(got.negative_flag),
						32'(want.negative_flag));
			end
		end
	end

	// receiver stalls in phases: always ready, random, mostly ready, mostly stalled
	initial begin : result_stall
		int mode, phase_left;
		phase_left = 0;
		mode = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (phase_left == 0) begin
				mode = $urandom_range(0, 3);
				phase_left = $urandom_range(20, 100);
			end
			case (mode)
				0:       result_ch.ready <= 1'b1;
				1:       result_ch.ready <= 1'($urandom_range(0, 1));
				2:       result_ch.ready <= ($urandom_range(0, 7) != 0);
				default: result_ch.ready <= ($urandom_range(0, 4) == 0);
			endcase
			phase_left--;
		end
	end

	// add / sub flag corners
	task automatic test_add_sub();
		send_instr(make_instr(CMD_ADD, 32'h7FFF_FFFF, 32'h1, 16'h0, 0, 0, 0, 16'h0));
		send_instr(make_instr(CMD_ADD1, 32'hFFFF_FFFF, 32'h1, 16'h0, 0, 0, 0, 16'hFFFF));
		send_instr(make_instr(CMD_SUB, 32'h8000_0000, 32'h1, 16'h0, 0, 0, 0, 16'h0));
		send_instr(make_instr(CMD_SUBI, 32'h0, 32'h1234, 16'h8000, 1, 0, 0, 16'h0));
	endtask

	// logic ops, constant loads, zero and reserved opcodes
	task automatic test_logic_loads();
		logic [CMD_W-1:0] rsv[4];
		rsv = '{CMD_RSV_10000, CMD_RSV_10001, CMD_RSV_10100, CMD_RSV_11011};
		send_instr(make_instr(CMD_XOR, 32'hF0F0_8001, 32'h0FF0_FFFF, 16'h0, 0, 0, 0, 16'h0));
		send_instr(make_instr(CMD_OR, 32'hFFFF_FFFF, 32'h0, 16'h0, 0, 0, 0, 16'h0));
		send_instr(make_instr(CMD_NOTA, 32'h0, 32'h0, 16'h0, 0, 0, 0, 16'h0));
		send_instr(make_instr(CMD_AND, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 16'h0, 0, 0, 0, 16'h0));
		send_instr(make_instr(CMD_PASSA, 32'h8000_0000, 32'h0, 16'h0, 0, 0, 0, 16'h0));
		send_instr(make_instr(CMD_NOR, 32'h0, 32'h0, 16'h0, 0, 0, 0, 16'h0));
		send_instr(make_instr(CMD_NAND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0, 0, 0, 0, 16'h0));
		send_instr(make_instr(CMD_LCH, 32'h0, 32'h0, 16'hFFFF, 1, 0, 0, 16'h0));
		send_instr(make_instr(CMD_LCL, 32'h0, 32'h0, 16'h8001, 1, 0, 0, 16'h0));
		send_instr(make_instr(CMD_ZERO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0, 0, 0, 0, 16'h0));
		foreach (rsv[i])
			send_instr(make_instr(rsv[i], 32'hFFFF_FFFF, 32'h1, 16'hFFFF, 0, 1, 1, 16'h4321));
	endtask

	// shift amounts of one, at the width edge and beyond
	task automatic test_shifts();
		send_instr(make_instr(CMD_ASL, 32'h8000_0001, 32'h1, 16'h0, 0, 0, 0, 16'h0));
		send_instr(make_instr(CMD_ASL, 32'h8000_0001, 32'd32, 16'h0, 0, 0, 0, 16'h0));
		send_instr(make_instr(CMD_ASR, 32'h8000_0000, 32'd31, 16'h0, 0, 0, 0, 16'h0));
		send_instr(make_instr(CMD_ASR, 32'h8000_0000, 32'h0, 16'hFFFF, 1, 0, 0, 16'h0));
		send_instr(make_instr(CMD_LSL, 32'h0000_0001, 32'd31, 16'h0, 0, 0, 0, 16'h0));
		send_instr(make_instr(CMD_LSR, 32'hFFFF_FFFF, 32'd40, 16'h0, 0, 0, 0, 16'h0));
	endtask

	// multiply carry and signed overflow
	task automatic test_mul();
		send_instr(make_instr(CMD_MUL, 32'h8000_0000, 32'hFFFF_FFFF, 16'h0, 0, 0, 0, 16'h0));
		send_instr(make_instr(CMD_MUL, 32'h0001_0000, 32'h0001_0000, 16'h0, 0, 0, 0, 16'h0));
		send_instr(make_instr(CMD_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0, 0, 0, 0, 16'h0));
	endtask

	// jumps with and without the jump flag
	task automatic test_jumps();
		send_instr(make_instr(CMD_JAL, 32'h0, 32'h0, 16'hABCD, 0, 0, 1, 16'h1234));
		send_instr(make_instr(CMD_JAL, 32'h0, 32'h0, 16'hFFFF, 0, 0, 1, 16'h0000));
		send_instr(make_instr(CMD_JR, 32'hDEAD_5678, 32'h0, 16'h0, 0, 0, 1, 16'h1111));
		send_instr(make_instr(CMD_J, 32'h0, 32'h0, 16'hFFFF, 0, 0, 1, 16'h2222));
		send_instr(make_instr(CMD_JAL, 32'h5, 32'h5, 16'hABCD, 0, 0, 0, 16'h1234));
		send_instr(make_instr(CMD_ADD, 32'h5, 32'h5, 16'hABCD, 0, 0, 1, 16'h1234));
	endtask

	// each branch, pc wrap both ways, branch flag missing or misplaced
	task automatic test_branches();
		send_instr(make_instr(CMD_BEQ, 32'h5, 32'h5, 16'h0004, 0, 1, 0, 16'hFFFE));
		send_instr(make_instr(CMD_BNE, 32'h5, 32'h5, 16'h0004, 0, 1, 0, 16'h0100));
		send_instr(make_instr(CMD_BGT, 32'h1, 32'hFFFF_FFFF, 16'h0010, 0, 1, 0, 16'h0100));
		send_instr(make_instr(CMD_BLT, 32'hFFFF_FFFF, 32'h0, 16'hFFF0, 0, 1, 0, 16'h0008));
		send_instr(make_instr(CMD_BGE, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0020, 0, 1, 0, 16'h0));
		send_instr(make_instr(CMD_BLE, 32'h8000_0000, 32'h0, 16'h7FFF, 0, 1, 0, 16'hFFFF));
		send_instr(make_instr(CMD_BEQ, 32'h7, 32'h7, 16'h0040, 0, 0, 0, 16'h0200));
		send_instr(make_instr(CMD_ADD, 32'h0, 32'h0, 16'h0040, 0, 1, 0, 16'h0200));
	endtask

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 4))
					0:       return 32'h0;
					1:       return 32'h1;
					2:       return 32'h7FFF_FFFF;
					3:       return 32'h8000_0000;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			1:       return $urandom_range(0, 40);
			2:       return 32'h0 - $urandom_range(1, 40);
			default: return $urandom;
		endcase
	endfunction

	// random words, control flags mostly matching the opcode
	task automatic test_random(input int n);
		in_word_t w;
		for (int i = 0; i < n; i++) begin
			if (i == n / 2)
				drain_pause();
			w.cmd = CMD_W'($urandom_range(0, 31));
			w.operand_a = rand_operand();
			w.operand_b = rand_operand();
			if ((w.cmd inside {CMD_ASL, CMD_ASR, CMD_LSL, CMD_LSR}) && $urandom_range(0, 3) != 0)
				w.operand_b = $urandom_range(0, 40);
			if ((w.cmd inside {CMD_BEQ, CMD_BNE, CMD_BGT, CMD_BLT, CMD_BGE, CMD_BLE})
				&& $urandom_range(0, 3) == 0)
				w.operand_b = w.operand_a;
			w.immediate = IMM_W'($urandom_range(0, 65535));
			w.use_immediate = ($urandom_range(0, 3) == 0);
			if (w.cmd inside {CMD_BEQ, CMD_BNE, CMD_BGT, CMD_BLT, CMD_BGE, CMD_BLE})
				w.is_branch = ($urandom_range(0, 7) != 0);
			else
				w.is_branch = ($urandom_range(0, 7) == 0);
			if (w.cmd inside {CMD_JAL, CMD_JR, CMD_J})
				w.is_jump = ($urandom_range(0, 7) != 0);
			else
				w.is_jump = ($urandom_range(0, 7) == 0);
			w.current_pc = PC_W'($urandom_range(0, 65535));
			send_instr(w);
		end
	endtask

	// stimulus sequence
	initial begin
		arst_n = 1'b0;
		insn_ch.valid = 1'b0;
		insn_ch.data = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_add_sub();
		test_logic_loads();
		test_shifts();
		test_mul();
		test_jumps();
		test_branches();
		test_random(RANDOM_WORDS);

		insn_ch.valid <= 1'b0;
		wait_for_drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
